@@ design/btc_pkg.sv @@
// btc_pkg: shared types and constants for the barometric trim compensation block.
// No dependencies; imported by btc_temp, baro_trim_compensation.
package btc_pkg;

    // configuration register index
    typedef enum logic [1:0] {
        CFG_TEMP_TRIM = 2'd0,
        CFG_PRES_LO   = 2'd1,
        CFG_PRES_HI   = 2'd2
    } cfg_sel_t;

    typedef logic signed [15:0] tq_t;     // temperature, 1/256 degC
    typedef logic        [23:0] raw_t;    // raw converter reading
    typedef logic signed [89:0] acc_t;    // pressure numerator over 2^65

    localparam int TEMP_TRIM_W = 40;
    localparam int TRIM_W      = 64;

    localparam logic signed [20:0] TQ_HI = 21'sd32767;
    localparam logic signed [20:0] TQ_LO = -21'sd32768;

    localparam logic signed [16:0] P_OFFSET = 17'sd16384;

    // v / 100 as (v * RECIP_100) >> RECIP_SHIFT, exact for v below 2^30
    localparam logic [30:0] RECIP_100   = 31'd1374389535;
    localparam int          RECIP_SHIFT = 37;
    localparam logic signed [36:0] V_SAT = 37'sd838860800;
    localparam logic [22:0] PRES_MAX    = 23'h7FFFFF;

endpackage

@@ design/baro_trim_compensation.sv @@
// baro_trim_compensation: top level of the barometric trim compensation pipeline.
// Depends on btc_pkg and btc_temp.
//
// Usage:
//   Sample channel: raw_temperature / raw_pressure with sample_valid; the block
//   raises sample_stall to hold the request off. A request is taken on a rising
//   edge with sample_valid high and sample_stall low.
//   Result channel: temperature_q8 / pressure_q12 with result_valid; the
//   receiver raises result_stall to hold the result.
//   Config channel: cfg_index / cfg_data with cfg_valid; cfg_ready is always
//   high. Index 0 = temperature trim, 1 = pressure trim low, 2 = pressure trim
//   high, 3 is ignored. Write only while the pipeline is empty.
// Timing: a 13-stage pipeline; one request is taken every cycle unless the
//   pipeline is stalled. The depth is set by the chain of multipliers
//   (temperature quadratic, then the temperature powers and the raw-pressure
//   products, split into 12-bit halves where wide), the 90-bit sum tree and
//   the divide-by-100 reciprocal multiply.
// Stall: the whole pipeline freezes while the output register holds a result
//   that the receiver stalls; sample_stall follows that condition directly.
// Reset: clears all valid bits and trim registers; no result is pending.
module baro_trim_compensation
    import btc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [23:0] raw_temperature,
    input  logic [23:0] raw_pressure,
    output logic        result_valid,
    input  logic        result_stall,
    output logic signed [15:0] temperature_q8,
    output logic [22:0] pressure_q12,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // trim registers
    logic [TEMP_TRIM_W-1:0] temp_trim_reg;
    logic [TRIM_W-1:0]      pres_lo_reg;
    logic [TRIM_W-1:0]      pres_hi_reg;

    // global advance: freeze only when a finished result is stalled
    logic en;
    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg <= '0;
            pres_lo_reg   <= '0;
            pres_hi_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_sel_t'(cfg_index))
                CFG_TEMP_TRIM: temp_trim_reg <= cfg_data[TEMP_TRIM_W-1:0];
                CFG_PRES_LO:   pres_lo_reg   <= cfg_data;
                CFG_PRES_HI:   pres_hi_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // trim fields
    logic signed [16:0] p1m, p2m;
    logic signed [16:0] p5s, p6s;
    logic signed [7:0]  p3, p4, p7, p8, p10, p11;
    logic signed [15:0] p9;

    assign p1m = $signed({pres_lo_reg[15], pres_lo_reg[15:0]}) - P_OFFSET;
    assign p2m = $signed({pres_lo_reg[31], pres_lo_reg[31:16]}) - P_OFFSET;
    assign p3  = pres_lo_reg[39:32];
    assign p4  = pres_lo_reg[47:40];
    assign p5s = $signed({1'b0, pres_lo_reg[63:48]});
    assign p6s = $signed({1'b0, pres_hi_reg[15:0]});
    assign p7  = pres_hi_reg[23:16];
    assign p8  = pres_hi_reg[31:24];
    assign p9  = pres_hi_reg[47:32];
    assign p10 = pres_hi_reg[55:48];
    assign p11 = pres_hi_reg[63:56];

    // stages 1..4: temperature
    logic vld4;
    tq_t  tq4;
    raw_t rp4;

    btc_temp u_temp (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (sample_valid),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .temp_trim       (temp_trim_reg),
        .out_valid       (vld4),
        .tq              (tq4),
        .rp              (rp4)
    );

    // valid bits of stages 5..13
    logic [8:0] vld_reg;

    // temperature travels alongside
    tq_t tq_reg [5:13];

    // stage 5
    logic signed [24:0] rps4;
    logic signed [31:0] tq2_5_reg, tq2_5_next;
    logic signed [32:0] b5_reg, b5_next;
    logic signed [49:0] rp2_5_reg, rp2_5_next;
    logic signed [41:0] e5_reg, e5_next;
    logic signed [41:0] rpp2_5_reg, rpp2_5_next;
    logic signed [32:0] rpp3_5_reg, rpp3_5_next;
    logic signed [23:0] p10tq_5_reg, p10tq_5_next;
    raw_t               rp5_reg;

    // stage 6
    logic signed [24:0] rps5;
    logic signed [47:0] tq3_6_reg, tq3_6_next;
    logic signed [39:0] c6_reg, c6_next;
    logic signed [57:0] f6_reg, f6_next;
    logic signed [64:0] g6_reg, g6_next;
    logic signed [65:0] i6_reg, i6_next;
    logic signed [57:0] rp2p11_6_reg, rp2p11_6_next;
    logic signed [48:0] ja6_reg, ja6_next;
    logic signed [32:0] b6_reg;
    logic signed [41:0] e6_reg;
    raw_t               rp6_reg;

    // stage 7
    logic signed [12:0] rlo6, rhi6;
    logic signed [55:0] d7_reg, d7_next;
    logic signed [55:0] p4tq3_7_reg, p4tq3_7_next;
    logic signed [61:0] jlo7_reg, jlo7_next, jhi7_reg, jhi7_next;
    logic signed [70:0] klo7_reg, klo7_next, khi7_reg, khi7_next;
    logic signed [32:0] b7_reg;
    logic signed [39:0] c7_reg;
    logic signed [41:0] e7_reg;
    logic signed [57:0] f7_reg;
    logic signed [64:0] g7_reg;
    logic signed [65:0] i7_reg;
    raw_t               rp7_reg;

    // stage 8
    logic signed [12:0] rlo7, rhi7;
    logic signed [68:0] hlo8_reg, hlo8_next, hhi8_reg, hhi8_next;
    logic signed [73:0] j8_reg, j8_next;
    logic signed [82:0] k8_reg, k8_next;
    logic signed [32:0] b8_reg;
    logic signed [39:0] c8_reg;
    logic signed [55:0] d8_reg;
    logic signed [41:0] e8_reg;
    logic signed [57:0] f8_reg;
    logic signed [64:0] g8_reg;
    logic signed [65:0] i8_reg;

    // stage 9..13
    acc_t               h9_reg, h9_next;
    acc_t               s1_9_reg, s1_9_next, s2_9_reg, s2_9_next, s3_9_reg, s3_9_next;
    acc_t               acc10_reg, acc10_next;
    logic signed [36:0] v10;
    logic               neg11_reg, neg11_next, big11_reg, big11_next;
    logic [29:0]        vc11_reg;
    logic [60:0]        prod12_reg, prod12_next;
    logic               neg12_reg, big12_reg;
    logic [22:0]        q13_reg, q13_next;

    always_comb
    begin
        rps4          = $signed({1'b0, rp4});
        tq2_5_next    = tq4 * tq4;
        b5_next       = p6s * tq4;
        rp2_5_next    = rps4 * rps4;
        e5_next       = rps4 * p1m;
        rpp2_5_next   = rps4 * p2m;
        rpp3_5_next   = rps4 * p3;
        p10tq_5_next  = p10 * tq4;

        rps5          = $signed({1'b0, rp5_reg});
        tq3_6_next    = tq2_5_reg * tq_reg[5];
        c6_next       = p7 * tq2_5_reg;
        f6_next       = rpp2_5_reg * tq_reg[5];
        g6_next       = rpp3_5_reg * tq2_5_reg;
        i6_next       = rp2_5_reg * p9;
        rp2p11_6_next = rp2_5_reg * p11;
        ja6_next      = rps5 * p10tq_5_reg;

        // raw pressure in two 12-bit halves for the wide products
        rlo6          = $signed({1'b0, rp6_reg[11:0]});
        rhi6          = $signed({1'b0, rp6_reg[23:12]});
        d7_next       = p8 * tq3_6_reg;
        p4tq3_7_next  = p4 * tq3_6_reg;
        jlo7_next     = ja6_reg * rlo6;
        jhi7_next     = ja6_reg * rhi6;
        klo7_next     = rp2p11_6_reg * rlo6;
        khi7_next     = rp2p11_6_reg * rhi6;

        rlo7          = $signed({1'b0, rp7_reg[11:0]});
        rhi7          = $signed({1'b0, rp7_reg[23:12]});
        hlo8_next     = p4tq3_7_reg * rlo7;
        hhi8_next     = p4tq3_7_reg * rhi7;
        j8_next       = (74'(jhi7_reg) <<< 12) + 74'(jlo7_reg);
        k8_next       = (83'(khi7_reg) <<< 12) + 83'(klo7_reg);

        // align every term to the 2^-65 grid
        h9_next   = (acc_t'(hhi8_reg) <<< 12) + acc_t'(hlo8_reg);
        s1_9_next = (acc_t'(p5s) <<< 68) + (acc_t'(b8_reg) <<< 51)
                  + (acc_t'(c8_reg) <<< 41) + (acc_t'(d8_reg) <<< 26);
        s2_9_next = (acc_t'(e8_reg) <<< 45) + (acc_t'(f8_reg) <<< 28)
                  + (acc_t'(g8_reg) <<< 17) + (acc_t'(i8_reg) <<< 17);
        s3_9_next = (acc_t'(j8_reg) <<< 9) + acc_t'(k8_reg);

        acc10_next = s1_9_reg + s2_9_reg + s3_9_reg + (h9_reg <<< 4);

        // hPa * 4096: floor(acc / 2^53) then floor divide by 100
        v10        = acc10_reg[89:53];
        neg11_next = v10[36];
        big11_next = (v10 >= V_SAT);

        prod12_next = 61'(vc11_reg) * 61'(RECIP_100);

        if (neg12_reg)
        begin
            q13_next = '0;
        end
        else if (big12_reg)
        begin
            q13_next = PRES_MAX;
        end
        else
        begin
            q13_next = prod12_reg[RECIP_SHIFT +: 23];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[7:0], vld4};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tq_reg[5]    <= tq4;
            for (int s = 6; s <= 13; s++)
            begin
                tq_reg[s] <= tq_reg[s-1];
            end

            tq2_5_reg    <= tq2_5_next;
            b5_reg       <= b5_next;
            rp2_5_reg    <= rp2_5_next;
            e5_reg       <= e5_next;
            rpp2_5_reg   <= rpp2_5_next;
            rpp3_5_reg   <= rpp3_5_next;
            p10tq_5_reg  <= p10tq_5_next;
            rp5_reg      <= rp4;

            tq3_6_reg    <= tq3_6_next;
            c6_reg       <= c6_next;
            f6_reg       <= f6_next;
            g6_reg       <= g6_next;
            i6_reg       <= i6_next;
            rp2p11_6_reg <= rp2p11_6_next;
            ja6_reg      <= ja6_next;
            b6_reg       <= b5_reg;
            e6_reg       <= e5_reg;
            rp6_reg      <= rp5_reg;

            d7_reg       <= d7_next;
            p4tq3_7_reg  <= p4tq3_7_next;
            jlo7_reg     <= jlo7_next;
            jhi7_reg     <= jhi7_next;
            klo7_reg     <= klo7_next;
            khi7_reg     <= khi7_next;
            b7_reg       <= b6_reg;
            c7_reg       <= c6_reg;
            e7_reg       <= e6_reg;
            f7_reg       <= f6_reg;
            g7_reg       <= g6_reg;
            i7_reg       <= i6_reg;
            rp7_reg      <= rp6_reg;

            hlo8_reg     <= hlo8_next;
            hhi8_reg     <= hhi8_next;
            j8_reg       <= j8_next;
            k8_reg       <= k8_next;
            b8_reg       <= b7_reg;
            c8_reg       <= c7_reg;
            d8_reg       <= d7_reg;
            e8_reg       <= e7_reg;
            f8_reg       <= f7_reg;
            g8_reg       <= g7_reg;
            i8_reg       <= i7_reg;

            h9_reg       <= h9_next;
            s1_9_reg     <= s1_9_next;
            s2_9_reg     <= s2_9_next;
            s3_9_reg     <= s3_9_next;

            acc10_reg    <= acc10_next;

            neg11_reg    <= neg11_next;
            big11_reg    <= big11_next;
            vc11_reg     <= v10[29:0];

            prod12_reg   <= prod12_next;
            neg12_reg    <= neg11_reg;
            big12_reg    <= big11_reg;

            q13_reg      <= q13_next;
        end
    end

    assign result_valid   = vld_reg[8];
    assign temperature_q8 = tq_reg[13];
    assign pressure_q12   = q13_reg;

endmodule

@@ design/btc_temp.sv @@
// btc_temp: four-stage temperature compensation pipeline (quadratic in raw - T1).
// Depends on btc_pkg; instantiated by baro_trim_compensation.
module btc_temp
    import btc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  raw_t                   raw_temperature,
    input  raw_t                   raw_pressure,
    input  logic [TEMP_TRIM_W-1:0] temp_trim,
    output logic                   out_valid,
    output tq_t                    tq,
    output raw_t                   rp
);

    logic [15:0]       t1;
    logic [15:0]       t2;
    logic signed [7:0] t3;

    logic [3:0]               vld_reg;
    logic signed [24:0]       d_reg, d_next;
    logic signed [41:0]       m1_reg, m1_next, m1b_reg;
    logic signed [49:0]       m2_reg, m2_next;
    logic signed [57:0]       m3_reg, m3_next;
    tq_t                      tq_reg, tq_next;
    raw_t                     rp1_reg, rp2_reg, rp3_reg, rp4_reg;
    logic signed [60:0]       num;
    logic signed [20:0]       tqw;

    assign t1 = temp_trim[15:0];
    assign t2 = temp_trim[31:16];
    assign t3 = temp_trim[39:32];

    always_comb
    begin
        d_next  = $signed({1'b0, raw_temperature}) - $signed({1'b0, t1, 8'b0});
        m1_next = d_reg * $signed({1'b0, t2});
        m2_next = d_reg * d_reg;
        m3_next = m2_reg * t3;
        num     = (61'(m1b_reg) <<< 18) + 61'(m3_reg);
        tqw     = num[60:40];
        if (tqw > TQ_HI)
        begin
            tq_next = tq_t'(TQ_HI);
        end
        else if (tqw < TQ_LO)
        begin
            tq_next = tq_t'(TQ_LO);
        end
        else
        begin
            tq_next = tqw[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= d_next;
            rp1_reg <= raw_pressure;
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
            rp2_reg <= rp1_reg;
            m1b_reg <= m1_reg;
            m3_reg  <= m3_next;
            rp3_reg <= rp2_reg;
            tq_reg  <= tq_next;
            rp4_reg <= rp3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign tq        = tq_reg;
    assign rp        = rp4_reg;

endmodule

@@ design/btc_checker.sv @@
// btc_checker: port-level assertions for baro_trim_compensation, with its bind.
// No package dependency; attaches to the top level by bind.
module btc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sample_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic signed [15:0] temperature_q8,
    input logic [22:0] pressure_q12,
    input logic        cfg_ready
);

    // stalled result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            ($stable(temperature_q8) && $stable(pressure_q12)))
        else $error("result payload changed under stall");

    // intake backs up only when the finished result is held
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == (result_valid && result_stall))
        else $error("sample_stall out of step with result stall");

    // config writes are never refused
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind baro_trim_compensation btc_checker u_btc_checker (.*);
